### sv/vnsl_pkg.sv
// ----------------------------------------------------------------------------
// vnsl_pkg: shared definitions for the nearest seed labeller
// Sizes of the seed chain, request codes and the word that travels between
// the cells of the chain.
// ----------------------------------------------------------------------------
package vnsl_pkg;

    localparam int MAX_SEEDS  = 16;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int COORD_W    = 11;
    localparam int CELL_W     = 10;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int OUT_DIST_W = 22;

    localparam logic [OUT_DIST_W-1:0] DIST_SAT = '1;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    // One word as it moves along the chain, with the running best match.
    typedef struct packed {
        logic                valid;
        logic                req_type;
        logic [SLOT_W-1:0]   seed_slot;
        logic [COORD_W-1:0]  seed_x;
        logic [COORD_W-1:0]  seed_y;
        logic [CELL_W-1:0]   cell_x;
        logic [CELL_W-1:0]   cell_y;
        logic                found;
        logic [SLOT_W-1:0]   label;
        logic [DIST_W-1:0]   best;
    } t_item;

endpackage

### sv/vnsl_cell.sv
// ----------------------------------------------------------------------------
// vnsl_cell: one seed cell of the labelling chain
// Holds one seed point. A load word for this slot updates the seed as it
// passes; a classify word picks up the squared distance to the seed in the
// first stage and folds it into the running best in the second.
// ----------------------------------------------------------------------------
module vnsl_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [vnsl_pkg::SLOT_W-1:0]   i_index,
    input  logic [vnsl_pkg::COUNT_W-1:0]  i_seed_count,
    input  vnsl_pkg::t_item               i_item,
    output vnsl_pkg::t_item               o_item
);
    import vnsl_pkg::*;

    logic [COORD_W-1:0] r_seed_x;
    logic [COORD_W-1:0] r_seed_y;
    t_item              r_a;
    logic [SQ_W-1:0]    r_sq_x;
    logic [SQ_W-1:0]    r_sq_y;
    t_item              r_b;

    logic [COORD_W-1:0] w_cx;
    logic [COORD_W-1:0] w_cy;
    logic [COORD_W-1:0] w_dx;
    logic [COORD_W-1:0] w_dy;
    logic [SQ_W-1:0]    n_sq_x;
    logic [SQ_W-1:0]    n_sq_y;
    logic [DIST_W-1:0]  w_dist;
    logic               w_active;
    logic               w_take;
    logic               w_load_here;
    t_item              n_b;

    // Cell coordinates are ten bits, so they never exceed the last grid cell.
    assign w_cx = {1'b0, i_item.cell_x};
    assign w_cy = {1'b0, i_item.cell_y};
    assign w_dx = (w_cx >= r_seed_x) ? (w_cx - r_seed_x) : (r_seed_x - w_cx);
    assign w_dy = (w_cy >= r_seed_y) ? (w_cy - r_seed_y) : (r_seed_y - w_cy);
    assign n_sq_x = w_dx * w_dx;
    assign n_sq_y = w_dy * w_dy;

    assign w_load_here = i_item.valid && (i_item.req_type == REQ_LOAD)
                         && (i_item.seed_slot == i_index);

    assign w_dist   = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign w_active = ({1'b0, i_index} < i_seed_count);
    assign w_take   = (r_a.req_type == REQ_CLASSIFY) && w_active
                      && (!r_a.found || (w_dist < r_a.best));

    always_comb begin
        n_b = r_a;
        if (w_take) begin
            n_b.found = 1'b1;
            n_b.label = i_index;
            n_b.best  = w_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
        end else if (i_adv) begin
            r_a    <= i_item;
            r_sq_x <= n_sq_x;
            r_sq_y <= n_sq_y;
            r_b    <= n_b;
            if (w_load_here) begin
                r_seed_x <= i_item.seed_x;
                r_seed_y <= i_item.seed_y;
            end
        end
    end

    assign o_item = r_b;

endmodule

### sv/voronoi_nearest_seed_labeler_unit.sv
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_labeler_unit: nearest seed labelling of grid cells
// A chain of sixteen seed cells, two register stages each, with an output
// register at its end. Every input word, load or classify, enters the chain
// and walks through all cells in order, so loads and classifies keep their
// order. A classify word reaches the output through every cell and the
// output register and gives the index of the nearest active seed (lowest
// index on ties) and its squared distance; a load word gives no result. The
// chain takes one word per clock whenever the output register is empty or
// being read, so the sustained rate is one word per cycle; a stall at the
// output holds the whole chain. The seed count register must only be
// written while the chain is empty.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_labeler_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vnsl_pkg::COUNT_W-1:0]     i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [vnsl_pkg::SLOT_W-1:0]      i_seed_slot,
    input  logic [vnsl_pkg::COORD_W-1:0]     i_seed_x,
    input  logic [vnsl_pkg::COORD_W-1:0]     i_seed_y,
    input  logic [vnsl_pkg::CELL_W-1:0]      i_cell_x,
    input  logic [vnsl_pkg::CELL_W-1:0]      i_cell_y,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic [vnsl_pkg::SLOT_W-1:0]      o_region_label,
    output logic [vnsl_pkg::OUT_DIST_W-1:0]  o_best_dist_sq
);
    import vnsl_pkg::*;

    logic [COUNT_W-1:0]    r_seed_count;
    logic                  r_out_valid;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_label;
    logic [OUT_DIST_W-1:0] r_dist;
    logic                  w_adv;
    t_item                 w_link [0:MAX_SEEDS];
    logic [OUT_DIST_W-1:0] n_dist;

    assign w_adv = !r_out_valid || i_out_ready;

    always_comb begin
        w_link[0]           = '0;
        w_link[0].valid     = i_in_valid;
        w_link[0].req_type  = i_req_type;
        w_link[0].seed_slot = i_seed_slot;
        w_link[0].seed_x    = i_seed_x;
        w_link[0].seed_y    = i_seed_y;
        w_link[0].cell_x    = i_cell_x;
        w_link[0].cell_y    = i_cell_y;
    end

    for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
        vnsl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (w_adv),
            .i_index      (SLOT_W'(g)),
            .i_seed_count (r_seed_count),
            .i_item       (w_link[g]),
            .o_item       (w_link[g+1])
        );
    end

    // Seeds outside their range can give a distance beyond the output field.
    assign n_dist = w_link[MAX_SEEDS].best[DIST_W-1]
                    ? DIST_SAT : w_link[MAX_SEEDS].best[OUT_DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed_count <= i_cfg_wdata;
            end
            if (w_adv) begin
                r_out_valid <= w_link[MAX_SEEDS].valid
                               && (w_link[MAX_SEEDS].req_type == REQ_CLASSIFY);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_found <= w_link[MAX_SEEDS].found;
            r_label <= w_link[MAX_SEEDS].label;
            r_dist  <= n_dist;
        end
    end

    assign o_in_ready     = w_adv;
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_region_label = r_label;
    assign o_best_dist_sq = r_dist;

endmodule

### sv/vnsl_checker.sv
// ----------------------------------------------------------------------------
// vnsl_checker: port level checks for the nearest seed labeller
// Watches the ports of the top level over time; attached by a bind.
// ----------------------------------------------------------------------------
module vnsl_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic                             o_found,
    input  logic [vnsl_pkg::SLOT_W-1:0]      o_region_label,
    input  logic [vnsl_pkg::OUT_DIST_W-1:0]  o_best_dist_sq
);
    import vnsl_pkg::*;

    // The chain only moves when the output word can move too.
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow the output stall");

    a_stalled_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_region_label) && $stable(o_best_dist_sq))
        else $error("stalled result word changed");

    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_region_label == '0) && (o_best_dist_sq == '0))
        else $error("result without a seed carries a label or distance");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

endmodule

bind voronoi_nearest_seed_labeler_unit vnsl_checker u_vnsl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_found        (o_found),
    .o_region_label (o_region_label),
    .o_best_dist_sq (o_best_dist_sq)
);

### verif/voronoi_nearest_seed_labeler_unit_tb.sv
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_labeler_unit_tb: self-checking bench for the labeller
// Loads seed points and classifies grid cells through the valid/ready ports.
// A behavioural predictor keeps its own seed table and seed count, and each
// result word is checked against the oldest prediction. Covers an empty
// table, ties, saturated distances, counts above the table size, output
// back-pressure and random traffic.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_labeler_unit_tb;

    import vnsl_pkg::*;

    // Long enough for a word, also a load word in flight, to pass through the whole chain.
    localparam int CHAIN_DRAIN = 40;

    typedef struct packed {
        logic                  found;
        logic [SLOT_W-1:0]     label;
        logic [OUT_DIST_W-1:0] dist_sq;
    } t_label_result;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [COUNT_W-1:0]    i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_req_type = REQ_LOAD;
    logic [SLOT_W-1:0]     i_seed_slot = '0;
    logic [COORD_W-1:0]    i_seed_x = '0;
    logic [COORD_W-1:0]    i_seed_y = '0;
    logic [CELL_W-1:0]     i_cell_x = '0;
    logic [CELL_W-1:0]     i_cell_y = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [SLOT_W-1:0]     o_region_label;
    logic [OUT_DIST_W-1:0] o_best_dist_sq;

    // Predictor state.
    logic [COORD_W-1:0]    seed_x_mem [MAX_SEEDS];
    logic [COORD_W-1:0]    seed_y_mem [MAX_SEEDS];
    logic [COUNT_W-1:0]    active_seeds = '0;
    t_label_result         pending_labels [$];

    int                    err_count = 0;
    int                    burst_left = 0;
    int                    hold_request = 0;
    int                    hold_left = 0;
    int                    style_left = 0;
    t_rx_style             rx_style = RX_OPEN;
    t_label_result         want;

    voronoi_nearest_seed_labeler_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_seed_slot    (i_seed_slot),
        .i_seed_x       (i_seed_x),
        .i_seed_y       (i_seed_y),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_region_label (o_region_label),
        .o_best_dist_sq (o_best_dist_sq)
    );

    always #10 i_clk = ~i_clk;

    // Brute-force search over the active seeds; only a strictly smaller
    // distance takes over, so the lowest index wins a tie.
    function automatic t_label_result nearest_seed_of(input logic [CELL_W-1:0] cx,
                                                      input logic [CELL_W-1:0] cy);
        t_label_result      r;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [DIST_W-1:0]  d;
        logic [DIST_W-1:0]  best;
        int                 n;
        r    = '0;
        best = '0;
        px   = {1'b0, cx};
        py   = {1'b0, cy};
        n    = (active_seeds > MAX_SEEDS) ? MAX_SEEDS : int'(active_seeds);
        for (int i = 0; i < n; i++) begin
            dx = (px >= seed_x_mem[i]) ? px - seed_x_mem[i] : seed_x_mem[i] - px;
            dy = (py >= seed_y_mem[i]) ? py - seed_y_mem[i] : seed_y_mem[i] - py;
            d  = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
            if (!r.found || d < best) begin
                r.found = 1'b1;
                r.label = SLOT_W'(i);
                best    = d;
            end
        end
        if (r.found)
            r.dist_sq = (best > DIST_W'(DIST_SAT)) ? DIST_SAT : best[OUT_DIST_W-1:0];
        return r;
    endfunction

    // Coordinates are biased towards the corners and beyond the stated range.
    function automatic logic [COORD_W-1:0] random_seed_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COORD_W'(1024);
            2: return '1;
            3: return COORD_W'($urandom_range(1025, 2047));
            default: return COORD_W'($urandom_range(0, 1024));
        endcase
    endfunction

    function automatic logic [CELL_W-1:0] random_cell_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return CELL_W'($urandom());
        endcase
    endfunction

    task automatic send_word(input logic               req,
                             input logic [SLOT_W-1:0]  slot,
                             input logic [COORD_W-1:0] sx,
                             input logic [COORD_W-1:0] sy,
                             input logic [CELL_W-1:0]  cx,
                             input logic [CELL_W-1:0]  cy);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_seed_slot <= slot;
        i_seed_x    <= sx;
        i_seed_y    <= sy;
        i_cell_x    <= cx;
        i_cell_y    <= cy;
        do @(posedge i_clk); while (!o_in_ready);
        // Words keep their order in the chain, so the table can be updated now.
        if (req == REQ_LOAD) begin
            seed_x_mem[slot] = sx;
            seed_y_mem[slot] = sy;
        end else begin
            pending_labels.push_back(nearest_seed_of(cx, cy));
        end
    endtask

    task automatic load_seed(input int slot, input int sx, input int sy);
        send_word(REQ_LOAD, SLOT_W'(slot), COORD_W'(sx), COORD_W'(sy), '0, '0);
    endtask

    task automatic classify_cell(input int cx, input int cy);
        send_word(REQ_CLASSIFY, SLOT_W'($urandom()), COORD_W'($urandom()),
                  COORD_W'($urandom()), CELL_W'(cx), CELL_W'(cy));
    endtask

    task automatic send_random_word();
        if ($urandom_range(0, 99) < 15)
            load_seed($urandom_range(0, MAX_SEEDS - 1), int'(random_seed_coord()),
                      int'(random_seed_coord()));
        else
            classify_cell(int'(random_cell_coord()), int'(random_cell_coord()));
    endtask

    // Stops offering words and waits until the chain has emptied.
    task automatic wait_chain_empty();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_labels.size() != 0) @(posedge i_clk);
        repeat (CHAIN_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_seed_count(input int value);
        wait_chain_empty();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= COUNT_W'(value);
        @(posedge i_clk);
        active_seeds = COUNT_W'(value);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic test_empty_table();
        classify_cell(0, 0);
        classify_cell(1023, 1023);
    endtask

    task automatic test_nearest_and_ties();
        load_seed(0, 0, 0);
        load_seed(1, 2047, 2047);
        load_seed(2, 1024, 1024);
        load_seed(3, 200, 100);
        load_seed(4, 0, 100);
        load_seed(15, 1024, 0);
        write_seed_count(5);
        // Seeds 3 and 4 lie at the same distance; the lower index must win.
        classify_cell(100, 100);
        classify_cell(1023, 1023);
        write_seed_count(1);
        classify_cell(1023, 0);
    endtask

    task automatic test_distance_saturation();
        load_seed(0, 2047, 2047);
        load_seed(1, 2047, 1500);
        write_seed_count(2);
        // For cell (0, 0) both distances exceed the output field, yet seed 1 is nearer.
        classify_cell(0, 0);
        classify_cell(1023, 1023);
    endtask

    task automatic test_load_all_slots();
        int order [MAX_SEEDS];
        for (int i = 0; i < MAX_SEEDS; i++) order[i] = i;
        order.shuffle();
        for (int i = 0; i < MAX_SEEDS; i++)
            load_seed(order[i], int'(random_seed_coord()), int'(random_seed_coord()));
    endtask

    task automatic test_count_above_table();
        write_seed_count(31);
        classify_cell(0, 0);
        classify_cell(1023, 512);
        write_seed_count(17);
        classify_cell(512, 1023);
        classify_cell(int'(random_cell_coord()), int'(random_cell_coord()));
        write_seed_count(16);
        classify_cell(1023, 1023);
        classify_cell(int'(random_cell_coord()), int'(random_cell_coord()));
    endtask

    task automatic test_random_phases();
        int counts [8] = '{16, 3, 31, 1, 0, 17, 12, 16};
        foreach (counts[p]) begin
            write_seed_count(counts[p]);
            repeat (80) send_random_word();
        end
        write_seed_count($urandom_range(0, 31));
        repeat (40) send_random_word();
    endtask

    task automatic test_output_backpressure();
        write_seed_count(16);
        hold_request = 300;
        repeat (120) send_random_word();
        wait_chain_empty();
    endtask

    task automatic test_drain_pause();
        repeat (30) send_random_word();
        wait_chain_empty();
        repeat (30) send_random_word();
    endtask

    // Receiver: a long hold when asked for, otherwise a changing stall pattern.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   = t_rx_style'($urandom_range(0, 3));
                style_left = $urandom_range(16, 96);
            end
            style_left--;
            case (rx_style)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:   i_out_ready <= ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_labels.size() == 0) begin
                $error("result word with no classify outstanding");
                err_count++;
            end else begin
                want = pending_labels.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    err_count++;
                end
                if (o_region_label !== want.label) begin
                    $error("region_label: expected %0d, got %0d", want.label,
                           o_region_label);
                    err_count++;
                end
                if (o_best_dist_sq !== want.dist_sq) begin
                    $error("best_dist_sq: expected %0d, got %0d", want.dist_sq,
                           o_best_dist_sq);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_nearest_and_ties();
        test_distance_saturation();
        test_load_all_slots();
        test_count_above_table();
        test_random_phases();
        test_output_backpressure();
        test_drain_pause();
        wait_chain_empty();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/vnsl_pkg.sv
sv/vnsl_cell.sv
sv/voronoi_nearest_seed_labeler_unit.sv
sv/vnsl_checker.sv
verif/voronoi_nearest_seed_labeler_unit_tb.sv
